[hw/rtl/tsfg_pkg.sv]
// ----------------------------------------------------------------------------
// tsfg_pkg: shared types and constants of the TCP SYN probe frame generator
// Item and result structs, configuration layout, header template constants
// and the one's-complement fold helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfg_pkg;

    // one probe target
    typedef struct packed {
        logic [31:0] target_ip;
        logic [15:0] target_port;
        logic [31:0] sequence_number;
    } in_item_t;

    // one 64-bit frame word
    typedef struct packed {
        logic [63:0] frame_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } out_item_t;

    // live configuration
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [7:0]  time_to_live;
    } cfg_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_DEST_MAC     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MAC   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PORT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_TO_LIVE = 3'd4;

    localparam logic [47:0] RST_DEST_MAC     = 48'h0001_0203_0405;
    localparam logic [47:0] RST_SOURCE_MAC   = 48'h0607_0809_0A0B;
    localparam logic [31:0] RST_SOURCE_IP    = 32'h0000_0000;
    localparam logic [15:0] RST_SOURCE_PORT  = 16'hFEDC;
    localparam logic [7:0]  RST_TIME_TO_LIVE = 8'hFF;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL      = 8'h45;
    localparam logic [7:0]  IP_TOS          = 8'h00;
    localparam logic [15:0] IP_TOTAL_LEN    = 16'd40;
    localparam logic [15:0] IP_FRAG         = 16'h0000;
    localparam logic [7:0]  IP_PROTO_NUM    = 8'h06;
    localparam logic [15:0] TCP_HDR_LEN     = 16'd20;
    localparam logic [7:0]  TCP_DATA_OFFSET = 8'h50;
    localparam logic [7:0]  TCP_FLAGS_SYN   = 8'h02;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned WORD_COUNT  = 7;
    localparam int unsigned FRAME_W     = WORD_W * WORD_COUNT;
    localparam int unsigned WORD_IDX_W  = 3;
    localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = 3'(WORD_COUNT - 1);
    localparam logic [3:0] FULL_BYTES   = 4'd8;
    localparam logic [3:0] LAST_BYTES   = 4'd6;

    // fold a 20-bit sum of 16-bit words with end-around carry
    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] t;
        logic [15:0] r;
        t = {1'b0, s[15:0]} + {13'b0, s[19:16]};
        r = t[15:0] + {15'b0, t[16]};
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tsfg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tsfg_cfg_regs: configuration register file
// Takes one register write per transfer; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfg_cfg_regs
    import tsfg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEST_MAC:     cfg_next.dest_mac     = cfg_data;
                REG_SOURCE_MAC:   cfg_next.source_mac   = cfg_data;
                REG_SOURCE_IP:    cfg_next.source_ip    = cfg_data[31:0];
                REG_SOURCE_PORT:  cfg_next.source_port  = cfg_data[15:0];
                REG_TIME_TO_LIVE: cfg_next.time_to_live = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_mac     <= RST_DEST_MAC;
            cfg_reg.source_mac   <= RST_SOURCE_MAC;
            cfg_reg.source_ip    <= RST_SOURCE_IP;
            cfg_reg.source_port  <= RST_SOURCE_PORT;
            cfg_reg.time_to_live <= RST_TIME_TO_LIVE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsfg_frame_build.sv]
// ----------------------------------------------------------------------------
// tsfg_frame_build: target register and frame assembly
// Holds one target and assembles the full 54-byte frame with both checksums.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfg_frame_build
    import tsfg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire in_item_t           target,
    input  wire cfg_t               cfg,
    input  wire logic               frame_take,
    output logic                    frame_valid,
    output logic [FRAME_W-1:0]      frame
);

    in_item_t    item_reg;
    logic        full_reg;
    logic        full_next;
    logic [15:0] ident;
    logic [19:0] ip_sum;
    logic [19:0] tcp_sum;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;

    assign busy        = full_reg;
    assign frame_valid = full_reg;

    always_comb
    begin
        full_next = full_reg;
        if (full_reg && frame_take)
            full_next = 1'b0;
        if (start && !full_reg)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (start && !full_reg)
            item_reg <= target;
    end

    assign ident = item_reg.target_ip[15:0] ^ item_reg.target_port
                 ^ item_reg.sequence_number[15:0];

    // header checksum field is zero while summing
    assign ip_sum = 20'({IP_VER_IHL, IP_TOS}) + 20'(IP_TOTAL_LEN) + 20'(ident)
                  + 20'(IP_FRAG) + 20'({cfg.time_to_live, IP_PROTO_NUM})
                  + 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
                  + 20'(item_reg.target_ip[31:16]) + 20'(item_reg.target_ip[15:0]);

    // pseudo-header plus TCP header; zero words left out
    assign tcp_sum = 20'(IP_PROTO_NUM) + 20'(TCP_HDR_LEN)
                   + 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
                   + 20'(item_reg.target_ip[31:16]) + 20'(item_reg.target_ip[15:0])
                   + 20'(cfg.source_port) + 20'(item_reg.target_port)
                   + 20'(item_reg.sequence_number[31:16])
                   + 20'(item_reg.sequence_number[15:0])
                   + 20'({TCP_DATA_OFFSET, TCP_FLAGS_SYN});

    assign ip_csum  = ~fold16(ip_sum);
    assign tcp_csum = ~fold16(tcp_sum);

    assign frame = {cfg.dest_mac, cfg.source_mac, ETHERTYPE_IPV4,
                    IP_VER_IHL, IP_TOS, IP_TOTAL_LEN, ident, IP_FRAG,
                    cfg.time_to_live, IP_PROTO_NUM, ip_csum,
                    cfg.source_ip, item_reg.target_ip,
                    cfg.source_port, item_reg.target_port,
                    item_reg.sequence_number, 32'h0,
                    TCP_DATA_OFFSET, TCP_FLAGS_SYN, 16'h0, tcp_csum, 16'h0,
                    16'h0};

endmodule

`default_nettype wire

[hw/rtl/tsfg_word_emit.sv]
// ----------------------------------------------------------------------------
// tsfg_word_emit: frame register and word sequencer
// Latches a finished frame and emits it as seven registered 64-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfg_word_emit
    import tsfg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [FRAME_W-1:0] frame,
    input  wire logic               frame_valid,
    output logic                    frame_take,
    output logic                    result_valid,
    output out_item_t               result
);

    logic [FRAME_W-1:0]    frame_reg;
    logic                  active_reg;
    logic                  active_next;
    logic [WORD_IDX_W-1:0] count_reg;
    logic [WORD_IDX_W-1:0] count_next;
    logic                  strobe_reg;
    out_item_t             result_reg;
    out_item_t             result_next;
    logic                  at_last;

    assign at_last    = (count_reg == LAST_WORD_IDX);
    // reload on the final word so frames leave back to back
    assign frame_take = frame_valid && (!active_reg || at_last);

    assign result_valid = strobe_reg;
    assign result       = result_reg;

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        if (active_reg)
        begin
            if (at_last)
                active_next = 1'b0;
            else
                count_next = count_reg + 1'b1;
        end
        if (frame_take)
        begin
            active_next = 1'b1;
            count_next  = '0;
        end
    end

    always_comb
    begin
        result_next.frame_word  = frame_reg[FRAME_W - 1 - WORD_W * count_reg -: WORD_W];
        result_next.valid_bytes = at_last ? LAST_BYTES : FULL_BYTES;
        result_next.last_word   = at_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
            frame_reg <= frame;
        if (active_reg)
            result_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> count_reg <= LAST_WORD_IDX)
        else $error("word index past end of frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !at_last |=> active_reg && count_reg == $past(count_reg) + 1'b1)
        else $error("word sequence broke mid frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.last_word |-> result_reg.valid_bytes == LAST_BYTES)
        else $error("final word carries wrong byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && at_last && !frame_valid |=> !active_reg)
        else $error("sequencer ran past frame end");

endmodule

`default_nettype wire

[hw/rtl/tcp_syn_probe_frame_generator_top.sv]
// ----------------------------------------------------------------------------
// tcp_syn_probe_frame_generator_top: TCP SYN probe frame generator
// Builds one Ethernet/IPv4/TCP SYN frame per target and streams it out.
// ----------------------------------------------------------------------------
// Each target accepted on start (while busy is low) yields one 54-byte frame,
// sent as seven 64-bit words on consecutive cycles with result_valid high for
// one cycle each; the receiver cannot stall and must take every word. The
// first word appears in the cycle after the frame is latched. An accepted
// target waits in the builder's target register until the word sequencer
// latches its frame; a new target can be accepted while a frame drains, and
// frames follow with no gap, since the next target is held and its checksums
// are ready while the current frame drains. Configuration writes are always
// ready and should only be issued while no frame is pending or in flight.
`default_nettype none

module tcp_syn_probe_frame_generator_top
    import tsfg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire in_item_t               target,
    output logic                        result_valid,
    output out_item_t                   result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t               cfg;
    logic               frame_valid;
    logic               frame_take;
    logic [FRAME_W-1:0] frame;

    tsfg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsfg_frame_build u_frame_build (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .target      (target),
        .cfg         (cfg),
        .frame_take  (frame_take),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    tsfg_word_emit u_word_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .frame_valid  (frame_valid),
        .frame_take   (frame_take),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
